>>> hw/rtl/sbwc_pkg.sv
// Shared widths, codes and helpers for the swept box wall collision core.
package sbwc_pkg;

	localparam int CW   = 32;
	localparam int FB   = 16;
	localparam int SW   = CW + 1;
	localparam int DMW  = CW + 1;
	localparam int LOB  = (DMW + 1) / 2;
	localparam int HIB  = DMW - LOB;
	localparam int SMW  = CW - 1;
	localparam int PMW  = SMW + DMW;
	localparam int OMW  = PMW - FB;
	localparam int OW   = OMW + 1;
	localparam int IW   = OW + 2;
	localparam int NB   = CW + 1 + FB;
	localparam int RW   = CW + 2;
	localparam int QCW  = $clog2(NB);
	localparam int DQW  = 2 * CW;
	localparam int CIW  = 2;

	localparam logic [CIW-1:0] REG_HB_LEFT   = CIW'(0);
	localparam logic [CIW-1:0] REG_HB_RIGHT  = CIW'(1);
	localparam logic [CIW-1:0] REG_HB_BOTTOM = CIW'(2);
	localparam logic [CIW-1:0] REG_HB_TOP    = CIW'(3);

	localparam logic signed [IW-1:0] CMAX_I = {{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [IW-1:0] CMIN_I = ~CMAX_I;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_START, CMD_WALL, CMD_SETUP, CMD_TEST, CMD_DIV_STEP, CMD_SLOPE,
		CMD_MUL1, CMD_MUL2, CMD_MUL3, CMD_MUL4, CMD_ISUM, CMD_NEXT_AXIS, CMD_KEEP,
		CMD_SLIDE, CMD_CLIP, CMD_SQX, CMD_SQY, CMD_UPDATE, CMD_EMIT
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETUP, ST_TEST, ST_DIV, ST_SLOPE, ST_MUL1, ST_MUL2, ST_MUL3,
		ST_MUL4, ST_ISUM, ST_ICMP, ST_NEXT, ST_KEEP, ST_SLIDE, ST_CLIP, ST_SQX,
		ST_SQY, ST_UPDATE, ST_EMIT
	} state_t;

	typedef struct packed {
		logic sp_zero;
		logic skip;
		logic div_last;
		logic hit;
		logic flush;
		logic axis;
		logic is_start;
		logic last;
		logic out_full;
	} status_t;

	function automatic logic signed [IW-1:0] sx(input logic signed [CW-1:0] v);
		return {{(IW-CW){v[CW-1]}}, v};
	endfunction

	function automatic logic signed [CW-1:0] sat_c(input logic signed [IW-1:0] v);
		logic signed [CW-1:0] r;
		r = v[CW-1:0];
		if (v > CMAX_I) r = CMAX_I[CW-1:0];
		else if (v < CMIN_I) r = CMIN_I[CW-1:0];
		return r;
	endfunction

endpackage

>>> hw/rtl/sbwc_ctrl.sv
// Sequencing state machine for the swept box wall collision core.
module sbwc_ctrl import sbwc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    func,
	input  status_t status,
	output logic    in_stall,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = func ? ST_SETUP : ST_SQX;
			ST_SETUP:  state_d = ST_TEST;
			ST_TEST: begin
				if (status.sp_zero) state_d = status.axis ? ST_KEEP : ST_NEXT;
				else if (status.skip) state_d = ST_KEEP;
				else state_d = ST_DIV;
			end
			ST_DIV:    if (status.div_last) state_d = ST_SLOPE;
			ST_SLOPE:  state_d = ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_MUL3;
			ST_MUL3:   state_d = ST_MUL4;
			ST_MUL4:   state_d = ST_ISUM;
			ST_ISUM:   state_d = ST_ICMP;
			ST_ICMP: begin
				if (status.hit) state_d = status.flush ? ST_SLIDE : ST_CLIP;
				else state_d = status.axis ? ST_KEEP : ST_NEXT;
			end
			ST_NEXT:   state_d = ST_SETUP;
			ST_KEEP, ST_SLIDE, ST_CLIP: state_d = ST_SQX;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_UPDATE;
			ST_UPDATE: state_d = status.last ? ST_EMIT : ST_IDLE;
			ST_EMIT:   if (!status.out_full) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = CMD_NONE;
		unique case (state_q)
			ST_IDLE:   if (in_valid) cmd = func ? CMD_WALL : CMD_START;
			ST_SETUP:  cmd = CMD_SETUP;
			ST_TEST:   cmd = CMD_TEST;
			ST_DIV:    cmd = CMD_DIV_STEP;
			ST_SLOPE:  cmd = CMD_SLOPE;
			ST_MUL1:   cmd = CMD_MUL1;
			ST_MUL2:   cmd = CMD_MUL2;
			ST_MUL3:   cmd = CMD_MUL3;
			ST_MUL4:   cmd = CMD_MUL4;
			ST_ISUM:   cmd = CMD_ISUM;
			ST_ICMP:   cmd = CMD_NONE;
			ST_NEXT:   cmd = CMD_NEXT_AXIS;
			ST_KEEP:   cmd = CMD_KEEP;
			ST_SLIDE:  cmd = CMD_SLIDE;
			ST_CLIP:   cmd = CMD_CLIP;
			ST_SQX:    cmd = CMD_SQX;
			ST_SQY:    cmd = CMD_SQY;
			ST_UPDATE: cmd = CMD_UPDATE;
			ST_EMIT:   cmd = status.out_full ? CMD_NONE : CMD_EMIT;
			default:   cmd = CMD_NONE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

>>> hw/rtl/sbwc_datapath.sv
// Registers, divider, multiplier and compare logic of the swept box wall collision core.
module sbwc_datapath import sbwc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic signed [CW-1:0]  old_x,
	input  logic signed [CW-1:0]  old_y,
	input  logic signed [CW-1:0]  new_x,
	input  logic signed [CW-1:0]  new_y,
	input  logic signed [CW-1:0]  wall_left,
	input  logic signed [CW-1:0]  wall_right,
	input  logic signed [CW-1:0]  wall_bottom,
	input  logic signed [CW-1:0]  wall_top,
	input  logic                  last_item,
	input  logic                  cfg_we,
	input  logic [CIW-1:0]        cfg_index,
	input  logic signed [CW-1:0]  cfg_data,
	input  logic                  out_stall,
	output status_t               status,
	output logic                  out_valid,
	output logic signed [CW-1:0]  final_x,
	output logic signed [CW-1:0]  final_y,
	output logic                  shortened
);

	logic signed [CW-1:0] hb_l_q, hb_r_q, hb_b_q, hb_t_q;
	logic signed [CW-1:0] start_x_q, start_y_q, best_x_q, best_y_q;
	logic [DQW-1:0]       best_d_q;
	logic                 shrt_q, axis_q, is_start_q, last_q, out_valid_q;
	logic signed [CW-1:0] wl_q, wr_q, wb_q, wt_q, rx_q, ry_q, face_q, lead_q;
	logic signed [CW-1:0] fx_q, fy_q;
	logic                 fs_q;
	logic signed [SW-1:0] sp_q, ss_q;
	logic [SW-1:0]        divisor_q;
	logic [NB-1:0]        dividend_q, quo_q;
	logic [RW-1:0]        rem_q;
	logic [QCW-1:0]       cnt_q;
	logic                 dneg_q, neg_q;
	logic [SMW-1:0]       sm_q;
	logic [DMW-1:0]       dm_q;
	logic [SMW+LOB-1:0]   acc_q, pp_q;
	logic [OMW-1:0]       omag_q;
	logic signed [OW-1:0] off_q;
	logic signed [IW-1:0] lo_i_q, hi_i_q;
	logic [DQW-1:0]       sqx_q, sqy_q;

	logic signed [CW-1:0] op, os, np, ns, hplo, hphi, hslo, hshi, wplo, wphi, wslo, wshi;
	logic                 sp_pos, skip;
	logic signed [IW-1:0] offx, travel, ssx, t3, tq, dsq, dmag, slide_s, clip_p, clip_s;
	logic [SW-1:0]        ss_mag, sp_mag;
	logic [RW-1:0]        rem_sh;
	logic                 ge;
	logic [SMW-1:0]       smag;
	logic [LOB-1:0]       mul_b;
	logic [SMW+LOB-1:0]   mul_r;
	logic [PMW-1:0]       psum;
	logic [DQW-1:0]       sq_r;
	logic [DQW:0]         dsum;
	logic [DQW-1:0]       dval;
	logic signed [CW-1:0] rp, rs;

	always_comb begin
		op   = axis_q ? start_y_q : start_x_q;
		os   = axis_q ? start_x_q : start_y_q;
		np   = axis_q ? best_y_q  : best_x_q;
		ns   = axis_q ? best_x_q  : best_y_q;
		hplo = axis_q ? hb_b_q : hb_l_q;
		hphi = axis_q ? hb_t_q : hb_r_q;
		hslo = axis_q ? hb_l_q : hb_b_q;
		hshi = axis_q ? hb_r_q : hb_t_q;
		wplo = axis_q ? wb_q : wl_q;
		wphi = axis_q ? wt_q : wr_q;
		wslo = axis_q ? wl_q : wb_q;
		wshi = axis_q ? wr_q : wt_q;
	end

	always_comb begin
		sp_pos = !sp_q[SW-1] && (sp_q != '0);
		if (sp_pos)
			skip = (sx(op) + sx(hplo) >= sx(wphi)) || (sx(np) + sx(hphi) <= sx(wplo));
		else
			skip = (sx(op) + sx(hphi) <= sx(wplo)) || (sx(np) + sx(hplo) >= sx(wphi));
		ss_mag = ss_q[SW-1] ? SW'(-ss_q) : SW'(ss_q);
		sp_mag = sp_q[SW-1] ? SW'(-sp_q) : SW'(sp_q);
		rem_sh = {rem_q[RW-2:0], dividend_q[NB-1]};
		ge     = rem_sh >= {1'b0, divisor_q};
		smag   = (quo_q[NB-1:CW-1] != '0) ? {SMW{1'b1}} : quo_q[CW-2:0];
		travel = sx(face_q) - sx(op) - sx(lead_q);
		mul_b  = (cmd == CMD_MUL1) ? dm_q[LOB-1:0] : LOB'(dm_q[DMW-1:LOB]);
		mul_r  = (SMW+LOB)'(sm_q) * (SMW+LOB)'(mul_b);
		psum   = PMW'(acc_q) + {pp_q[SMW+HIB-1:0], {LOB{1'b0}}};
		offx   = {{(IW-OW){off_q[OW-1]}}, off_q};
		ssx    = {{(IW-SW){ss_q[SW-1]}}, ss_q};
		t3     = (ssx <<< 1) + ssx;
		tq     = (t3 + (t3[IW-1] ? IW'(3) : IW'(0))) >>> 2;
		slide_s = sx(os) + tq;
		clip_p = sx(face_q) - sx(lead_q);
		clip_s = offx + sx(os);
		dsq    = (cmd == CMD_SQX) ? sx(rx_q) - sx(start_x_q) : sx(ry_q) - sx(start_y_q);
		dmag   = dsq[IW-1] ? -dsq : dsq;
		sq_r   = (dmag[IW-1:CW] != '0) ? {DQW{1'b1}} : DQW'(dmag[CW-1:0]) * DQW'(dmag[CW-1:0]);
		dsum   = {1'b0, sqx_q} + {1'b0, sqy_q};
		dval   = dsum[DQW] ? {DQW{1'b1}} : dsum[DQW-1:0];
		rp     = (cmd == CMD_SLIDE) ? op : sat_c(clip_p);
		rs     = (cmd == CMD_SLIDE) ? sat_c(slide_s) : sat_c(clip_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_l_q <= '0; hb_r_q <= '0; hb_b_q <= '0; hb_t_q <= '0;
			start_x_q <= '0; start_y_q <= '0; best_x_q <= '0; best_y_q <= '0;
			best_d_q <= '0; shrt_q <= 1'b0; axis_q <= 1'b0; is_start_q <= 1'b0;
			last_q <= 1'b0; out_valid_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HB_LEFT:   hb_l_q <= cfg_data;
					REG_HB_RIGHT:  hb_r_q <= cfg_data;
					REG_HB_BOTTOM: hb_b_q <= cfg_data;
					REG_HB_TOP:    hb_t_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd == CMD_EMIT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (cmd)
				CMD_START: begin
					start_x_q <= old_x; start_y_q <= old_y;
					best_x_q <= new_x; best_y_q <= new_y;
					is_start_q <= 1'b1; last_q <= last_item;
				end
				CMD_WALL: begin
					is_start_q <= 1'b0; last_q <= last_item; axis_q <= 1'b0;
				end
				CMD_NEXT_AXIS: axis_q <= 1'b1;
				CMD_TEST: cnt_q <= '0;
				CMD_DIV_STEP: cnt_q <= cnt_q + QCW'(1);
				CMD_UPDATE: begin
					if (is_start_q) begin
						best_d_q <= dval; shrt_q <= 1'b0;
					end else if (dval < best_d_q) begin
						best_x_q <= rx_q; best_y_q <= ry_q;
						best_d_q <= dval; shrt_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_START: begin
				rx_q <= new_x; ry_q <= new_y;
			end
			CMD_WALL: begin
				wl_q <= wall_left; wr_q <= wall_right; wb_q <= wall_bottom; wt_q <= wall_top;
			end
			CMD_SETUP: begin
				sp_q <= SW'(sx(np) - sx(op));
				ss_q <= SW'(sx(ns) - sx(os));
			end
			CMD_TEST: begin
				face_q     <= sp_pos ? wplo : wphi;
				lead_q     <= sp_pos ? hphi : hplo;
				divisor_q  <= sp_mag;
				dividend_q <= {ss_mag, {FB{1'b0}}};
				rem_q      <= '0;
				neg_q      <= ss_q[SW-1] ^ sp_q[SW-1];
			end
			CMD_DIV_STEP: begin
				rem_q      <= ge ? rem_sh - {1'b0, divisor_q} : rem_sh;
				quo_q      <= {quo_q[NB-2:0], ge};
				dividend_q <= {dividend_q[NB-2:0], 1'b0};
			end
			CMD_SLOPE: begin
				sm_q   <= smag;
				dm_q   <= travel[IW-1] ? DMW'(-travel) : DMW'(travel);
				dneg_q <= travel[IW-1];
			end
			CMD_MUL1: acc_q <= mul_r;
			CMD_MUL2: pp_q <= mul_r;
			CMD_MUL3: omag_q <= psum[PMW-1:FB];
			CMD_MUL4: off_q <= (neg_q ^ dneg_q) ? -$signed({1'b0, omag_q})
			                                     : $signed({1'b0, omag_q});
			CMD_ISUM: begin
				lo_i_q <= offx + sx(os) + sx(hslo);
				hi_i_q <= offx + sx(os) + sx(hshi);
			end
			CMD_KEEP: begin
				rx_q <= best_x_q; ry_q <= best_y_q;
			end
			CMD_SLIDE, CMD_CLIP: begin
				if (axis_q) begin
					ry_q <= rp; rx_q <= rs;
				end else begin
					rx_q <= rp; ry_q <= rs;
				end
			end
			CMD_SQX: sqx_q <= sq_r;
			CMD_SQY: sqy_q <= sq_r;
			CMD_EMIT: begin
				fx_q <= best_x_q; fy_q <= best_y_q; fs_q <= shrt_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		status.sp_zero  = (sp_q == '0);
		status.skip     = skip;
		status.div_last = (cnt_q == QCW'(NB - 1));
		status.hit      = (lo_i_q > sx(wslo) && lo_i_q < sx(wshi)) ||
		                  (hi_i_q > sx(wslo) && hi_i_q < sx(wshi)) ||
		                  (lo_i_q < sx(wslo) && hi_i_q > sx(wshi));
		status.flush    = (sx(op) + sx(lead_q)) == sx(face_q);
		status.axis     = axis_q;
		status.is_start = is_start_q;
		status.last     = last_q;
		status.out_full = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign final_x   = fx_q;
	assign final_y   = fy_q;
	assign shortened = fs_q;

endmodule

>>> hw/rtl/swept_box_wall_collision_core.sv
// Top level of the swept box wall collision core.
//
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  func, old/new x y, wall edges, last_item
//  out      out        out_valid/out_stall  final_x, final_y, shortened
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A start request can end in a result; a wall request tests the axes against the
// wall. Each tested axis that reaches the slope state runs through the 49-step
// restoring divider that yields one quotient bit per cycle.
// Reset clears the hitbox, the held positions and the best distance to zero.
// A result waits in the output register; a further result holds until it is taken.
module swept_box_wall_collision_core import sbwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic signed [CW-1:0] old_x,
	input  logic signed [CW-1:0] old_y,
	input  logic signed [CW-1:0] new_x,
	input  logic signed [CW-1:0] new_y,
	input  logic signed [CW-1:0] wall_left,
	input  logic signed [CW-1:0] wall_right,
	input  logic signed [CW-1:0] wall_bottom,
	input  logic signed [CW-1:0] wall_top,
	input  logic                 last_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [CW-1:0] final_x,
	output logic signed [CW-1:0] final_y,
	output logic                 shortened,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CIW-1:0]       cfg_index,
	input  logic signed [CW-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	sbwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	sbwc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.old_x       (old_x),
		.old_y       (old_y),
		.new_x       (new_x),
		.new_y       (new_y),
		.wall_left   (wall_left),
		.wall_right  (wall_right),
		.wall_bottom (wall_bottom),
		.wall_top    (wall_top),
		.last_item   (last_item),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.status      (status),
		.out_valid   (out_valid),
		.final_x     (final_x),
		.final_y     (final_y),
		.shortened   (shortened)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("request accepted twice");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_EMIT) |-> !out_valid) else $error("result overwritten");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd == CMD_EMIT)) else $error("result without emit");

endmodule
